@@ design/bmw_pkg.sv @@
// Shared types, register map and command codes of the board management register file.
package bmw_pkg;

  localparam int REG_COUNT = 32;
  localparam int CTL_COUNT = 12;
  localparam int CTL_AW    = $clog2(CTL_COUNT);
  localparam int GEN_DEPTH = REG_COUNT - CTL_COUNT;
  localparam int GEN_AW    = (GEN_DEPTH > 1) ? $clog2(GEN_DEPTH) : 1;

  typedef enum logic [2:0] {
    FN_ADDR     = 3'd0,
    FN_WRITE    = 3'd1,
    FN_READ     = 3'd2,
    FN_TICK     = 3'd3,
    FN_PIN      = 3'd4,
    FN_FAN_DONE = 3'd5,
    FN_FAN_OVF  = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ACT_NONE       = 2'd0,
    ACT_REBOOT     = 2'd1,
    ACT_RESET      = 2'd2,
    ACT_POWER_DOWN = 2'd3
  } action_t;

  localparam logic [CTL_AW-1:0] RG_CMD     = CTL_AW'(0);
  localparam logic [CTL_AW-1:0] RG_STATUS  = CTL_AW'(1);
  localparam logic [CTL_AW-1:0] RG_TIMEOUT = CTL_AW'(2);
  localparam logic [CTL_AW-1:0] RG_REASON  = CTL_AW'(3);
  localparam logic [CTL_AW-1:0] RG_RSTCNT  = CTL_AW'(4);
  localparam logic [CTL_AW-1:0] RG_TEMP    = CTL_AW'(5);
  localparam logic [CTL_AW-1:0] RG_VOLT    = CTL_AW'(6);
  localparam logic [CTL_AW-1:0] RG_FAN     = CTL_AW'(7);
  localparam logic [CTL_AW-1:0] RG_FANLO   = CTL_AW'(8);
  localparam logic [CTL_AW-1:0] RG_FANHI   = CTL_AW'(9);
  localparam logic [CTL_AW-1:0] RG_SECLO   = CTL_AW'(10);
  localparam logic [CTL_AW-1:0] RG_SECHI   = CTL_AW'(11);

  localparam logic [7:0] CMD_SAFE_RESET = 8'h0D;
  localparam logic [7:0] CMD_FEED       = 8'h11;
  localparam logic [7:0] CMD_REBOOT     = 8'h12;
  localparam logic [7:0] CMD_RESET      = 8'h66;
  localparam logic [7:0] CMD_POWER_DOWN = 8'hF7;
  localparam logic [7:0] CMD_CLEAR_ERR  = 8'h86;

  localparam logic [7:0] REASON_REBOOT     = 8'd1;
  localparam logic [7:0] REASON_RESET      = 8'd2;
  localparam logic [7:0] REASON_POWER_DOWN = 8'd3;
  localparam logic [7:0] REASON_WATCHDOG   = 8'd4;

  localparam logic [7:0] FAN_FAIL = 8'h01;

  localparam logic [2:0] PIN_CHIP_TEMP = 3'd0;
  localparam logic [2:0] PIN_DDR_GOOD  = 3'd1;
  localparam logic [2:0] PIN_REG_TEMP  = 3'd2;
  localparam logic [2:0] PIN_CORE_GOOD = 3'd3;
  localparam logic [2:0] PIN_RESET_REQ = 3'd4;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    action_t    action;
    logic       start_fan;
    logic       err_int;
    logic       sys_rst;
    logic       led;
  } result_t;

  // One step of the control logic as seen by the datapath.
  typedef struct packed {
    result_t           res;
    logic              rd_ram;
    logic              ram_we;
    logic [GEN_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata;
  } step_t;

endpackage

@@ design/bmw_ram.sv @@
// Generic single-port RAM with registered read data.
module bmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ design/bmw_ctrl.sv @@
// Control registers, pointer, commands, watchdog, alarm pins and fan check.
module bmw_ctrl import bmw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  func_t       func,
  input  logic        rnw,
  input  logic [7:0]  data_byte,
  input  logic [2:0]  pin_select,
  input  logic        pin_level,
  input  logic [15:0] fan_count,
  output step_t       step
);

  logic [7:0]  ctl_reg [CTL_COUNT];
  logic [7:0]  ctl_reg_next [CTL_COUNT];
  logic [7:0]  reg_pointer, reg_pointer_next;
  logic        expect_pointer, expect_pointer_next;
  logic [15:0] seconds, seconds_next;
  // Seconds since the last feed; bounded by the timeout while the watchdog runs.
  logic [7:0]  dog_age, dog_age_next;
  logic        dog_running, dog_running_next;
  logic        error_line, error_line_next;
  logic        fan_pending, fan_pending_next;
  logic        reset_line, reset_line_next;
  logic        led_level, led_level_next;

  always_comb begin
    logic              in_range;
    logic              in_ctl;
    logic [CTL_AW-1:0] ctl_idx;
    logic [7:0]        ptr_off;
    logic [7:0]        ptr_inc;
    logic [8:0]        age_inc;
    logic [7:0]        cmd;
    action_t           act;
    action_t           bite;
    logic              do_read;

    in_range = {1'b0, reg_pointer} < 9'(REG_COUNT);
    in_ctl   = reg_pointer < 8'(CTL_COUNT);
    ctl_idx  = reg_pointer[CTL_AW-1:0];
    ptr_off  = reg_pointer - 8'(CTL_COUNT);
    ptr_inc  = reg_pointer + 8'd1;
    age_inc  = {1'b0, dog_age} + 9'd1;
    act      = ACT_NONE;
    bite     = ACT_NONE;
    do_read  = 1'b0;

    ctl_reg_next        = ctl_reg;
    reg_pointer_next    = reg_pointer;
    expect_pointer_next = expect_pointer;
    seconds_next        = seconds;
    dog_age_next        = dog_age;
    dog_running_next    = dog_running;
    error_line_next     = error_line;
    fan_pending_next    = fan_pending;
    reset_line_next     = reset_line;
    led_level_next      = led_level;

    step.ram_we    = 1'b0;
    step.ram_addr  = ptr_off[GEN_AW-1:0];
    step.ram_wdata = data_byte;
    step.res.start_fan = 1'b0;

    case (func)
      FN_ADDR: begin
        if (rnw) begin
          do_read = 1'b1;
        end else begin
          expect_pointer_next = 1'b1;
        end
      end
      FN_WRITE: begin
        if (expect_pointer) begin
          reg_pointer_next    = data_byte;
          expect_pointer_next = 1'b0;
        end else if (in_range) begin
          if (in_ctl) begin
            ctl_reg_next[ctl_idx] = data_byte;
          end else begin
            step.ram_we = 1'b1;
          end
          reg_pointer_next = ptr_inc;
        end
      end
      FN_READ: begin
        do_read = 1'b1;
      end
      FN_TICK: begin
        if (error_line) begin
          led_level_next = ~led_level;
        end
        seconds_next = seconds + 16'd1;
        ctl_reg_next[RG_SECLO] = seconds_next[7:0];
        ctl_reg_next[RG_SECHI] = seconds_next[15:8];
        if (dog_running) begin
          if (ctl_reg[RG_TIMEOUT] == 8'd0) begin
            ctl_reg_next[RG_TIMEOUT] = 8'd0;
            dog_running_next         = 1'b0;
          end else if (age_inc > {1'b0, ctl_reg[RG_TIMEOUT]}) begin
            ctl_reg_next[RG_REASON]  = REASON_WATCHDOG;
            ctl_reg_next[RG_TIMEOUT] = 8'd0;
            dog_running_next         = 1'b0;
            bite = ctl_reg[RG_STATUS][0] ? ACT_RESET : ACT_REBOOT;
          end else begin
            dog_age_next = age_inc[7:0];
          end
        end else if (ctl_reg[RG_TIMEOUT] != 8'd0) begin
          dog_age_next     = 8'd0;
          dog_running_next = 1'b1;
        end
        if (!seconds_next[0]) begin
          if (fan_pending) begin
            error_line_next      = 1'b1;
            ctl_reg_next[RG_FAN] = FAN_FAIL;
          end else begin
            fan_pending_next   = 1'b1;
            step.res.start_fan = 1'b1;
          end
        end
      end
      FN_PIN: begin
        case (pin_select)
          PIN_CHIP_TEMP: begin
            ctl_reg_next[RG_TEMP][0] = ~pin_level;
            if (!pin_level) error_line_next = 1'b1;
          end
          PIN_DDR_GOOD: begin
            ctl_reg_next[RG_VOLT][1] = ~pin_level;
            if (!pin_level) error_line_next = 1'b1;
          end
          PIN_REG_TEMP: begin
            ctl_reg_next[RG_TEMP][1] = ~pin_level;
            if (!pin_level) error_line_next = 1'b1;
          end
          PIN_CORE_GOOD: begin
            ctl_reg_next[RG_VOLT][0] = ~pin_level;
            if (!pin_level) error_line_next = 1'b1;
          end
          PIN_RESET_REQ: begin
            reset_line_next = pin_level;
            led_level_next  = pin_level;
            if (pin_level) begin
              ctl_reg_next[RG_RSTCNT] = ctl_reg[RG_RSTCNT] + 8'd1;
            end
          end
          default: begin
          end
        endcase
      end
      FN_FAN_DONE: begin
        ctl_reg_next[RG_FANLO] = fan_count[7:0];
        ctl_reg_next[RG_FANHI] = fan_count[15:8];
        ctl_reg_next[RG_FAN]   = 8'd0;
        fan_pending_next       = 1'b0;
      end
      FN_FAN_OVF: begin
        error_line_next      = 1'b1;
        ctl_reg_next[RG_FAN] = FAN_FAIL;
      end
      default: begin
      end
    endcase

    if (do_read) begin
      reg_pointer_next = ptr_inc;
    end

    // The command register is evaluated after every transfer, on the updated file.
    cmd = ctl_reg_next[RG_CMD];
    case (cmd) inside
      CMD_SAFE_RESET: begin
        ctl_reg_next[RG_STATUS][0] = 1'b1;
      end
      CMD_FEED: begin
        dog_age_next         = 8'd0;
        ctl_reg_next[RG_CMD] = 8'd0;
      end
      CMD_REBOOT, CMD_RESET: begin
        ctl_reg_next[RG_TIMEOUT] = 8'd0;
        dog_running_next         = 1'b0;
        ctl_reg_next[RG_REASON]  = (cmd == CMD_REBOOT) ? REASON_REBOOT : REASON_RESET;
        act = (cmd == CMD_REBOOT) ? ACT_REBOOT : ACT_RESET;
        ctl_reg_next[RG_RSTCNT]  = ctl_reg_next[RG_RSTCNT] + 8'd1;
        ctl_reg_next[RG_CMD]     = 8'd0;
      end
      CMD_POWER_DOWN: begin
        ctl_reg_next[RG_TIMEOUT] = 8'd0;
        dog_running_next         = 1'b0;
        ctl_reg_next[RG_REASON]  = REASON_POWER_DOWN;
        act = ACT_POWER_DOWN;
        ctl_reg_next[RG_CMD]     = 8'd0;
      end
      CMD_CLEAR_ERR: begin
        error_line_next      = 1'b0;
        ctl_reg_next[RG_CMD] = 8'd0;
      end
      default: begin
      end
    endcase

    step.res.read_valid = do_read;
    step.res.read_data  = (do_read && in_ctl) ? ctl_reg[ctl_idx] : 8'd0;
    step.rd_ram         = do_read && in_range && !in_ctl;
    step.res.action     = (act != ACT_NONE) ? act : bite;
    step.res.err_int    = error_line_next;
    step.res.sys_rst    = reset_line_next;
    step.res.led        = led_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CTL_COUNT; i++) begin
        ctl_reg[i] <= 8'd0;
      end
      reg_pointer    <= 8'd0;
      expect_pointer <= 1'b1;
      seconds        <= 16'd0;
      dog_age        <= 8'd0;
      dog_running    <= 1'b0;
      error_line     <= 1'b0;
      fan_pending    <= 1'b0;
      reset_line     <= 1'b0;
      led_level      <= 1'b0;
    end else if (accept) begin
      ctl_reg        <= ctl_reg_next;
      reg_pointer    <= reg_pointer_next;
      expect_pointer <= expect_pointer_next;
      seconds        <= seconds_next;
      dog_age        <= dog_age_next;
      dog_running    <= dog_running_next;
      error_line     <= error_line_next;
      fan_pending    <= fan_pending_next;
      reset_line     <= reset_line_next;
      led_level      <= led_level_next;
    end
  end

endmodule

@@ design/board_mgmt_i2c_regfile_watchdog.sv @@
// Top level: byte register file with watchdog, alarm bits and fan check behind stream ports.
// A result is registered in stage s1 and then in the output register, held there until taken.
// Throughput: one item per cycle while the output is not stalled; the single RAM port is the limit.
// Registers 0 to 11 sit in flip-flops; the rest sit in a RAM written and read at transfer time.
// Reset (synchronous) resets all control state; RAM entries read as zero until first written,
// tracked by one written bit per entry, so no clearing pass is needed after reset.
module board_mgmt_i2c_regfile_watchdog import bmw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rnw[0], data_byte[8:1], pin_select[11:9], pin_level[12], fan_count[28:13], zero[31:29]
  input  logic [31:0] s_axis_tdata,
  // func[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], read_valid[8], action[10:9], start_fan[11], err_int[12],
  // sys_rst[13], led[14], zero[15]
  output logic [15:0] m_axis_tdata
);

  step_t          step;
  logic           accept;
  logic           s1_valid;
  logic           s1_adv;
  result_t        s1_res;
  logic           s1_ram;
  logic           out_valid;
  result_t        out_res;
  result_t        out_res_next;
  logic [7:0]     ram_rdata;
  logic [GEN_DEPTH-1:0] gen_written;

  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bmw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (func_t'(s_axis_tuser)),
    .rnw        (s_axis_tdata[0]),
    .data_byte  (s_axis_tdata[8:1]),
    .pin_select (s_axis_tdata[11:9]),
    .pin_level  (s_axis_tdata[12]),
    .fan_count  (s_axis_tdata[28:13]),
    .step       (step)
  );

  // Writes and reads both happen at the transfer edge, so a read always sees earlier writes.
  bmw_ram #(
    .WIDTH (8),
    .DEPTH (GEN_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && step.ram_we),
    .re    (accept && step.rd_ram),
    .addr  (step.ram_addr),
    .wdata (step.ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_written <= '0;
    end else if (accept && step.ram_we) begin
      gen_written[step.ram_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= step.res;
      s1_ram <= step.rd_ram && gen_written[step.ram_addr];
    end
  end

  always_comb begin
    out_res_next = s1_res;
    if (s1_ram) begin
      out_res_next.read_data = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= out_res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res.led, out_res.sys_rst, out_res.err_int,
                          out_res.start_fan, out_res.action, out_res.read_valid,
                          out_res.read_data};

endmodule
